[rtl/core/shbi_pkg.sv]
// ----------------------------------------------------------------------------
// shbi_pkg
// Shared types and constants for the string hash bucket index unit.
// ----------------------------------------------------------------------------
package shbi_pkg;

   localparam int CHAR_W       = 8;
   localparam int HASH_W       = 64;
   localparam int MODE_W       = 2;
   localparam int COUNT_W      = 25;
   localparam int INDEX_W      = 24;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 25;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_HASH_MODE    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUCKET_COUNT = 1'd1;

   localparam logic [MODE_W-1:0] MODE_MODULO     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MID_SQUARE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PRIME      = 2'd2;

   localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_MODULO;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 25'd1024;

   localparam int PRIME_TABLE_LEN = 24;
   localparam logic [INDEX_W-1:0] PRIME_TABLE [PRIME_TABLE_LEN] = '{
      24'd1, 24'd2, 24'd3, 24'd7, 24'd13, 24'd31, 24'd61, 24'd127, 24'd251,
      24'd509, 24'd1021, 24'd2039, 24'd4093, 24'd8191, 24'd16381, 24'd32749,
      24'd65521, 24'd131071, 24'd262139, 24'd524287, 24'd1048573,
      24'd2097143, 24'd4194301, 24'd8388593
   };

   typedef struct packed {
      logic [MODE_W-1:0]  hash_mode;
      logic [COUNT_W-1:0] bucket_count;
   } cfg_type;

endpackage

[rtl/core/shbi_front.sv]
// ----------------------------------------------------------------------------
// shbi_front
// Character intake: keeps the running base-31 hash and hands each finished
// key hash to the queue.
// ----------------------------------------------------------------------------
module shbi_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [shbi_pkg::CHAR_W-1:0] req_char_code,
   input  logic                              req_last_char,
   input  logic                              queue_full,
   output logic                              push,
   output logic [shbi_pkg::HASH_W-1:0]       push_hash
);
   import shbi_pkg::*;

   logic [HASH_W-1:0] acc_ff;
   logic [HASH_W-1:0] acc_in;
   logic [HASH_W-1:0] acc_next;
   logic              accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // acc * 31 + sign-extended char
   assign acc_next = (acc_ff << 5) - acc_ff + HASH_W'(req_char_code);

   assign push      = accept && req_last_char;
   assign push_hash = acc_next;

   always_comb begin
      acc_in = acc_ff;
      if (accept) begin
         acc_in = req_last_char ? '0 : acc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

[rtl/core/shbi_queue.sv]
// ----------------------------------------------------------------------------
// shbi_queue
// Short queue of finished key hashes between intake and bucket unit.
// ----------------------------------------------------------------------------
module shbi_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [shbi_pkg::HASH_W-1:0] push_hash,
   output logic                        full,
   output logic                        pop_valid,
   input  logic                        pop,
   output logic [shbi_pkg::HASH_W-1:0] pop_hash
);
   import shbi_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [HASH_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_hash  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (full && !pop) |=> (count_ff == CNT_W'(QUEUE_DEPTH)))
      else $error("queue lost its fill level");

endmodule

[rtl/core/shbi_back.sv]
// ----------------------------------------------------------------------------
// shbi_back
// Bucket unit: bit-serial remainder or split middle-square, with a result
// register toward the response channel.
// ----------------------------------------------------------------------------
module shbi_back #(
   parameter int BUCKET_BITS = 24,
   parameter int PRIME_COUNT = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  shbi_pkg::cfg_type                   cfg,
   input  logic                                pop_valid,
   output logic                                pop,
   input  logic [shbi_pkg::HASH_W-1:0]         pop_hash,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [shbi_pkg::INDEX_W-1:0]        rsp_bucket_index,
   output logic signed [shbi_pkg::HASH_W-1:0]  rsp_raw_hash
);
   import shbi_pkg::*;

   localparam logic [32:0] TOP_COUNT = 33'(1) << BUCKET_BITS;
   localparam int PRIME_N = (PRIME_COUNT < PRIME_TABLE_LEN) ? PRIME_COUNT : PRIME_TABLE_LEN;
   localparam int LOG_W   = $clog2(COUNT_W);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_SQ1    = 3'd2;
   localparam logic [2:0] ST_SQ2    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   function automatic logic [LOG_W-1:0] floor_log2(input logic [COUNT_W-1:0] v);
      logic [LOG_W-1:0] k;
      k = '0;
      for (int i = 1; i < COUNT_W; i++) begin
         if (v[i]) begin
            k = LOG_W'(i);
         end
      end
      return k;
   endfunction

   logic [2:0]         state_ff, state_in;
   logic [HASH_W-1:0]  hash_ff, hash_in;
   logic [HASH_W-1:0]  mag_ff, mag_in;
   logic [COUNT_W-1:0] div_ff, div_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [5:0]         bit_cnt_ff, bit_cnt_in;
   logic [LOG_W-1:0]   k_ff, k_in;
   logic [HASH_W-1:0]  p_ff, p_in;
   logic [30:0]        q_ff, q_in;
   logic               square_ff, square_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] bucket_ff, bucket_in;
   logic [HASH_W-1:0]  raw_ff, raw_in;

   logic [32:0]        count_wide;
   logic [COUNT_W-1:0] eff_count;
   logic [COUNT_W-1:0] best_prime;
   logic               prime_fallback;
   logic [COUNT_W:0]   rem_shift;
   logic [31:0]        mul_b;
   logic [HASH_W-1:0]  mul_out;
   logic [HASH_W-1:0]  square;
   logic [6:0]         shamt;
   logic [INDEX_W-1:0] sq_index;
   logic               load_rsp;

   // effective bucket count and table prime
   always_comb begin
      count_wide = {8'd0, cfg.bucket_count};
      if (count_wide == '0) begin
         count_wide = 33'd1;
      end
      if (count_wide > TOP_COUNT) begin
         count_wide = TOP_COUNT;
      end
      eff_count = count_wide[COUNT_W-1:0];
      best_prime = COUNT_W'(1);
      for (int i = 0; i < PRIME_N; i++) begin
         if ({1'b0, PRIME_TABLE[i]} <= eff_count) begin
            best_prime = {1'b0, PRIME_TABLE[i]};
         end
      end
      prime_fallback = ({1'b0, PRIME_TABLE[PRIME_N-1]} < eff_count);
   end

   // shared 32x32 multiplier for the split square
   assign mul_b   = (state_ff == ST_SQ1) ? hash_ff[31:0] : hash_ff[63:32];
   assign mul_out = HASH_W'(hash_ff[31:0]) * HASH_W'(mul_b);

   assign rem_shift = {rem_ff, mag_ff[HASH_W-1]};
   assign square    = p_ff + {q_ff, 33'd0};
   assign shamt     = 7'd64 - {2'd0, k_ff};
   assign sq_index  = (k_ff == '0) ? '0 : INDEX_W'(square >> shamt);
   assign load_rsp  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign pop       = (state_ff == ST_IDLE) && pop_valid;

   always_comb begin
      state_in   = state_ff;
      hash_in    = hash_ff;
      mag_in     = mag_ff;
      div_in     = div_ff;
      rem_in     = rem_ff;
      bit_cnt_in = bit_cnt_ff;
      k_in       = k_ff;
      p_in       = p_ff;
      q_in       = q_ff;
      square_in  = square_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               hash_in    = pop_hash;
               mag_in     = pop_hash[HASH_W-1] ? (HASH_W'(0) - pop_hash) : pop_hash;
               rem_in     = '0;
               bit_cnt_in = 6'd63;
               k_in       = floor_log2(eff_count);
               square_in  = 1'b0;
               div_in     = eff_count;
               unique case (cfg.hash_mode)
                  MODE_MID_SQUARE: square_in = 1'b1;
                  MODE_PRIME:      div_in = prime_fallback ? eff_count : best_prime;
                  default:         div_in = eff_count;
               endcase
               state_in = square_in ? ST_SQ1 : ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_shift >= {1'b0, div_ff}) begin
               rem_in = COUNT_W'(rem_shift - {1'b0, div_ff});
            end else begin
               rem_in = rem_shift[COUNT_W-1:0];
            end
            mag_in     = mag_ff << 1;
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_SQ1: begin
            p_in     = mul_out;
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            q_in     = mul_out[30:0];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      bucket_in    = bucket_ff;
      raw_in       = raw_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         bucket_in    = square_ff ? sq_index : rem_ff[INDEX_W-1:0];
         raw_in       = hash_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff    <= hash_in;
      mag_ff     <= mag_in;
      div_ff     <= div_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
      k_ff       <= k_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      square_ff  <= square_in;
      bucket_ff  <= bucket_in;
      raw_ff     <= raw_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bucket_index = bucket_ff;
   assign rsp_raw_hash     = raw_ff;

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < div_ff))
      else $error("partial remainder not below divisor");

   a_sq_sequence: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ1) |=> (state_ff == ST_SQ2))
      else $error("square steps out of order");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_FINISH))
      else $error("result overwrote a stalled transfer");

endmodule

[rtl/core/string_hash_bucket_index_unit.sv]
// ----------------------------------------------------------------------------
// string_hash_bucket_index_unit
// Streaming base-31 string hash with bucket selection.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle and folded into a 64-bit running hash.
// Each finished key hash goes into a two-entry queue; the bucket unit then
// takes one hash at a time. Modulo and table-prime modes use a bit-serial
// remainder over all 64 magnitude bits between a load step and a finish
// step; middle-square mode uses one shared 32x32 multiplier twice. The
// intake stalls only when the queue holds two unfinished hashes, so keys
// longer than the bucket unit's work per key run at one character per
// cycle while the result side does not stall.
// ----------------------------------------------------------------------------
module string_hash_bucket_index_unit #(
   parameter int BUCKET_BITS = 24,
   parameter int PRIME_COUNT = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [shbi_pkg::CHAR_W-1:0]     req_char_code,
   input  logic                                   req_last_char,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [shbi_pkg::INDEX_W-1:0]           rsp_bucket_index,
   output logic signed [shbi_pkg::HASH_W-1:0]     rsp_raw_hash,
   input  logic                                   csr_write_enable,
   input  logic [shbi_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [shbi_pkg::CSR_DATA_W-1:0]        csr_write_data
);
   import shbi_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   logic              queue_full;
   logic              push;
   logic [HASH_W-1:0] push_hash;
   logic              pop_valid;
   logic              pop;
   logic [HASH_W-1:0] pop_hash;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HASH_MODE:    cfg_in.hash_mode    = csr_write_data[MODE_W-1:0];
            CSR_BUCKET_COUNT: cfg_in.bucket_count = csr_write_data[COUNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hash_mode    <= MODE_RESET;
         cfg_ff.bucket_count <= COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   shbi_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .queue_full    (queue_full),
      .push          (push),
      .push_hash     (push_hash)
   );

   shbi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_hash (push_hash),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_hash  (pop_hash)
   );

   shbi_back #(
      .BUCKET_BITS (BUCKET_BITS),
      .PRIME_COUNT (PRIME_COUNT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .pop_valid        (pop_valid),
      .pop              (pop),
      .pop_hash         (pop_hash),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bucket_index (rsp_bucket_index),
      .rsp_raw_hash     (rsp_raw_hash)
   );

endmodule

[bench/bucket_index_checker.sv]
// ----------------------------------------------------------------------------
// bucket_index_checker
// Watches the character, result and register ports of the string hash unit,
// keeps its own running base-31 hash and register copies, predicts the
// bucket index and raw hash of every finished key and compares each result
// transfer in order against the oldest prediction.
// ----------------------------------------------------------------------------
module bucket_index_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic signed [shbi_pkg::CHAR_W-1:0]      req_char_code,
   input  logic                                    req_last_char,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic [shbi_pkg::INDEX_W-1:0]            rsp_bucket_index,
   input  logic signed [shbi_pkg::HASH_W-1:0]      rsp_raw_hash,
   input  logic                                    csr_write_enable,
   input  logic [shbi_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [shbi_pkg::CSR_DATA_W-1:0]         csr_write_data,
   output int                                      fail_count,
   output int                                      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import shbi_pkg::*;

   localparam int          TABLE_BITS = 24;
   localparam logic [63:0] POLY_RADIX = 64'd31;
   localparam int          PRIMES     = 24;
   localparam logic [63:0] PRIME_LIST [PRIMES] = '{
      64'd1, 64'd2, 64'd3, 64'd7, 64'd13, 64'd31, 64'd61, 64'd127, 64'd251,
      64'd509, 64'd1021, 64'd2039, 64'd4093, 64'd8191, 64'd16381, 64'd32749,
      64'd65521, 64'd131071, 64'd262139, 64'd524287, 64'd1048573,
      64'd2097143, 64'd4194301, 64'd8388593
   };

   typedef struct packed {
      logic [INDEX_W-1:0] bucket_index;
      logic [HASH_W-1:0]  raw_hash;
   } key_result_type;

   key_result_type      expected_keys [$];
   logic [HASH_W-1:0]   key_hash_acc = '0;
   logic [MODE_W-1:0]   cur_mode     = MODE_RESET;
   logic [COUNT_W-1:0]  cur_count    = COUNT_RESET;
   int                  mismatches   = 0;
   int                  keys_due     = 0;

   assign fail_count    = mismatches;
   assign pending_count = keys_due;

   // |hash| mod divisor, magnitude taken as unsigned so the most negative hash works
   function automatic logic [63:0] magnitude_mod(input logic [63:0] key_hash,
                                                 input logic [63:0] divisor);
      logic [63:0] mag;
      mag = key_hash[63] ? -key_hash : key_hash;
      return mag % divisor;
   endfunction

   function automatic logic [INDEX_W-1:0] bucket_for_hash(input logic [63:0] key_hash,
                                                          input logic [MODE_W-1:0] mode,
                                                          input logic [COUNT_W-1:0] count_reg);
      logic [63:0] count;
      logic [63:0] square;
      logic [63:0] best;
      logic [63:0] prime;
      logic [63:0] bucket;
      int          log_bits;
      count = count_reg;
      if (count == 0) count = 1;
      if (count > (64'd1 << TABLE_BITS)) count = 64'd1 << TABLE_BITS;
      bucket = magnitude_mod(key_hash, count);
      case (mode)
         MODE_MID_SQUARE: begin
            log_bits = 0;
            while ((count >> (log_bits + 1)) != 0) log_bits++;
            square = key_hash * key_hash;
            bucket = (log_bits == 0) ? 64'd0 : square >> (64 - log_bits);
         end
         MODE_PRIME: begin
            best  = 64'd1;
            prime = 64'd1;
            for (int i = 0; i < PRIMES; i++) begin
               prime = PRIME_LIST[i];
               if (prime > count) break;
               best = prime;
            end
            // only a count strictly above the last prime falls back to the count
            bucket = (prime < count) ? magnitude_mod(key_hash, count)
                                     : magnitude_mod(key_hash, best);
         end
         default: ;
      endcase
      return bucket[INDEX_W-1:0];
   endfunction

   always @(posedge clock) begin : track
      key_result_type want;
      if (reset) begin
         expected_keys.delete();
         key_hash_acc = '0;
         cur_mode     = MODE_RESET;
         cur_count    = COUNT_RESET;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_HASH_MODE:    cur_mode  = csr_write_data[MODE_W-1:0];
               CSR_BUCKET_COUNT: cur_count = csr_write_data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_keys.size() == 0) begin
               mismatches++;
               $display("%0t: result transfer with none expected: bucket_index %0d raw_hash %h",
                        $time, rsp_bucket_index, rsp_raw_hash);
            end else begin
               want = expected_keys.pop_front();
               if (rsp_bucket_index !== want.bucket_index) begin
                  mismatches++;
                  $display("%0t: bucket_index mismatch: expected %0d actual %0d",
                           $time, want.bucket_index, rsp_bucket_index);
               end
               if (rsp_raw_hash !== want.raw_hash) begin
                  mismatches++;
                  $display("%0t: raw_hash mismatch: expected %h actual %h",
                           $time, want.raw_hash, rsp_raw_hash);
               end
            end
         end
         if (req_valid && !req_stall) begin
            key_hash_acc = key_hash_acc * POLY_RADIX
                         + {{(HASH_W-CHAR_W){req_char_code[CHAR_W-1]}}, req_char_code};
            if (req_last_char) begin
               want.raw_hash     = key_hash_acc;
               want.bucket_index = bucket_for_hash(key_hash_acc, cur_mode, cur_count);
               expected_keys.push_back(want);
               key_hash_acc = '0;
            end
         end
      end
      keys_due <= expected_keys.size();
   end

endmodule

[bench/string_hash_bucket_index_unit_tb.sv]
// ----------------------------------------------------------------------------
// string_hash_bucket_index_unit_tb
// Drives keys into the string hash unit under a series of mode and bucket
// count settings, with random gaps and result-side stalls, and lets the
// bucket index checker predict and compare every result.
// ----------------------------------------------------------------------------
module string_hash_bucket_index_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import shbi_pkg::*;

   localparam int                CYCLE_LIMIT   = 1_000_000;
   localparam int                SETTLE_CYCLES = 80;
   localparam int                PHASE_CHARS   = 62;
   localparam int                RANDOM_PHASES = 4;
   localparam int                FIXED_PHASES  = 14;
   localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;

   localparam logic [MODE_W-1:0] PHASE_MODE [FIXED_PHASES] = '{
      MODE_MODULO, MODE_MID_SQUARE, MODE_MID_SQUARE, MODE_MID_SQUARE, MODE_MID_SQUARE,
      MODE_PRIME, MODE_PRIME, MODE_PRIME, MODE_PRIME, MODE_PRIME, MODE_PRIME,
      MODE_SPARE, MODE_MODULO, MODE_MODULO
   };
   localparam logic [COUNT_W-1:0] PHASE_COUNT [FIXED_PHASES] = '{
      25'd0, 25'd1, 25'd2, 25'd16777216, 25'h1FFFFFF,
      25'd1, 25'd2, 25'd1021, 25'd8388593, 25'd8388594, 25'd16777216,
      25'd1000, 25'd16777215, 25'h1FFFFFF
   };

   logic                         clock            = 1'b0;
   logic                         reset            = 1'b1;
   logic                         req_valid        = 1'b0;
   logic                         req_stall;
   logic signed [CHAR_W-1:0]     req_char_code    = '0;
   logic                         req_last_char    = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall        = 1'b0;
   logic [INDEX_W-1:0]           rsp_bucket_index;
   logic signed [HASH_W-1:0]     rsp_raw_hash;
   logic                         csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]       csr_index        = CSR_HASH_MODE;
   logic [CSR_DATA_W-1:0]        csr_write_data   = '0;
   int                           fail_count;
   int                           pending_count;
   int                           cycle_count      = 0;
   int                           phase_chars      = 0;
   bit                           idle_gaps        = 1'b0;

   string_hash_bucket_index_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_last_char    (req_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bucket_index (rsp_bucket_index),
      .rsp_raw_hash     (rsp_raw_hash),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   bucket_index_checker index_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_last_char    (req_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bucket_index (rsp_bucket_index),
      .rsp_raw_hash     (rsp_raw_hash),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: free-flowing stretches, random stalls and the odd long stall
   initial begin : rsp_pacing
      int run;
      forever begin
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         run = $urandom_range(5, 60);
         repeat (run) begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
            @(posedge clock);
         end
         if ($urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end
      end
   end

   task automatic send_char(input logic [CHAR_W-1:0] code, input logic last);
      int gap;
      int pick;
      gap  = 0;
      pick = $urandom_range(0, 19);
      if (idle_gaps && pick >= 10)
         gap = (pick < 18) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= code;
      req_last_char <= last;
      do @(posedge clock); while (req_stall);
      phase_chars++;
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic drain();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] count);
      logic [31:0] junk;
      junk = $urandom;
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_HASH_MODE;
      csr_write_data   <= {junk[CSR_DATA_W-MODE_W-1:0], mode};
      @(posedge clock);
      csr_index        <= CSR_BUCKET_COUNT;
      csr_write_data   <= count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // digits of -2^63 in base 31, so the key hashes to the most negative value
   task automatic send_min_hash_key();
      longint signed rest;
      longint signed digit;
      logic [CHAR_W-1:0] digits [$];
      rest = longint'(64'h8000_0000_0000_0000);
      while (rest != 0) begin
         digit = rest % 31;
         if (digit < -15) digit += 31;
         digits.push_front(digit[CHAR_W-1:0]);
         rest = (rest - digit) / 31;
      end
      foreach (digits[i]) send_char(digits[i], i == digits.size() - 1);
   endtask

   task automatic send_key(input int key_len);
      logic [CHAR_W-1:0] code;
      int pick;
      for (int i = 0; i < key_len; i++) begin
         pick = $urandom_range(0, 15);
         case (pick)
            0:       code = 8'h80;
            1:       code = 8'h7f;
            2:       code = 8'h00;
            default: code = CHAR_W'($urandom_range(0, 255));
         endcase
         send_char(code, i == key_len - 1);
      end
   endtask

   initial begin : stimulus
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] count;
      logic [31:0]        bits;
      int                 pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: extreme single characters, zero, the most negative hash and a repeated 0x7f key
      send_char(8'h80, 1'b1);
      send_char(8'h7f, 1'b1);
      send_char(8'h00, 1'b1);
      send_min_hash_key();
      repeat (5) send_char(8'h7f, 1'b0);
      send_char(8'h7f, 1'b1);

      for (int p = 0; p < FIXED_PHASES + RANDOM_PHASES; p++) begin
         drain();
         if (p < FIXED_PHASES) begin
            mode  = PHASE_MODE[p];
            count = PHASE_COUNT[p];
         end else begin
            mode  = MODE_W'($urandom_range(0, 3));
            bits  = $urandom;
            count = bits[COUNT_W-1:0] >> $urandom_range(0, COUNT_W - 1);
         end
         set_config(mode, count);
         idle_gaps   = ($urandom_range(0, 3) != 0);
         phase_chars = 0;
         while (phase_chars < PHASE_CHARS) begin
            pick = $urandom_range(0, 24);
            if (pick == 0)
               wait_results();
            if (pick == 1)
               send_min_hash_key();
            else if (pick < 15)
               send_key($urandom_range(1, 6));
            else if (pick < 23)
               send_key($urandom_range(7, 20));
            else
               send_key($urandom_range(40, 90));
         end
      end

      drain();
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/shbi_pkg.sv
rtl/core/shbi_front.sv
rtl/core/shbi_queue.sv
rtl/core/shbi_back.sv
rtl/core/string_hash_bucket_index_unit.sv
bench/bucket_index_checker.sv
bench/string_hash_bucket_index_unit_tb.sv
